// ----- rtl/pq8_pkg.sv -----
`default_nettype none

package pq8_pkg;

    localparam int unsigned LANES       = 4;
    localparam int unsigned CFG_W       = 64;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned PIX_W       = 8;
    localparam int unsigned COEF_W      = 16;
    // scale * byte fits 25 bits, bias is pre-shifted by 4 to land on 2^-10 units
    localparam int unsigned PROD_W      = COEF_W + PIX_W + 1;
    localparam int unsigned ACC_W       = PROD_W + 1;
    localparam int unsigned FRAC_BITS   = 10;
    localparam int unsigned BIAS_SHIFT  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE = 3'd0,
        REG_BIAS  = 3'd1,
        REG_FMT   = 3'd2,
        REG_SWAP  = 3'd3,
        REG_KEEP  = 3'd4
    } pq8_reg_t;

    typedef enum logic [1:0] {
        FMT_BGRA = 2'd0,
        FMT_BGR  = 2'd1,
        FMT_GRAY = 2'd2,
        FMT_RSVD = 2'd3
    } pq8_fmt_t;

    typedef struct packed {
        logic [PIX_W-1:0] lane3;
        logic [PIX_W-1:0] lane2;
        logic [PIX_W-1:0] lane1;
        logic [PIX_W-1:0] lane0;
        logic             last;
    } pq8_result_t;

endpackage

`default_nettype wire

// ----- rtl/pixel_quantize_to_int8_unit.sv -----
// Pixel quantizer: one pixel of up to four bytes in, four saturated int8 lanes out,
// lane k = round(scale_k * byte + bias_k) with scale in Q5.10 and bias in Q9.6,
// rounded half away from zero. Four lane cores run side by side, each a two-stage
// pipe (multiply, then bias/round/saturate), followed by an output register with
// a skid slot. Throughput is one pixel per clock while the skid slot is empty;
// a pixel passes the multiply register, the lane result register and the output
// register in turn. Write the configuration registers only while no pixel is in
// flight. pixel_format 3 behaves as gray.
`default_nettype none

module pixel_quantize_to_int8_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [pq8_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pq8_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_chan0,
    input  wire logic [7:0]                     s_chan1,
    input  wire logic [7:0]                     s_chan2,
    input  wire logic [7:0]                     s_chan3,
    input  wire logic                           s_last_pixel,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [7:0]                   m_lane0,
    output logic signed [7:0]                   m_lane1,
    output logic signed [7:0]                   m_lane2,
    output logic signed [7:0]                   m_lane3,
    output logic                                m_last_pixel_out
);
    import pq8_pkg::*;

    logic [CFG_W-1:0]  scale_reg;
    logic [CFG_W-1:0]  bias_reg;
    pq8_fmt_t          fmt_reg;
    logic              swap_reg;
    logic              keep_reg;

    logic              pipe_en;
    logic              v1_reg;
    logic              v2_reg;
    logic              last1_reg;
    logic              last2_reg;
    logic              is_gray;
    logic              swap_eff;
    logic [PIX_W-1:0]  pix   [LANES];
    logic [LANES-1:0]  active;
    logic [PIX_W-1:0]  lane_q[LANES];
    pq8_result_t       res;
    pq8_result_t       out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= '0;
            bias_reg  <= '0;
            fmt_reg   <= FMT_BGRA;
            swap_reg  <= 1'b0;
            keep_reg  <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SCALE: scale_reg <= cfg_data;
                REG_BIAS:  bias_reg  <= cfg_data;
                REG_FMT:   fmt_reg   <= pq8_fmt_t'(cfg_data[1:0]);
                REG_SWAP:  swap_reg  <= cfg_data[0];
                REG_KEEP:  keep_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign is_gray  = (fmt_reg inside {FMT_GRAY, FMT_RSVD});
    assign swap_eff = swap_reg && !is_gray;

    assign pix[0] = swap_eff ? s_chan2 : s_chan0;
    assign pix[1] = s_chan1;
    assign pix[2] = swap_eff ? s_chan0 : s_chan2;
    assign pix[3] = s_chan3;

    assign active[0] = 1'b1;
    assign active[1] = !is_gray;
    assign active[2] = !is_gray;
    assign active[3] = (fmt_reg == FMT_BGRA) && keep_reg;

    // whole pipe moves together; it only holds while the skid slot is occupied
    assign s_ready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            last1_reg <= s_last_pixel;
            last2_reg <= last1_reg;
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        pq8_lane u_lane (
            .aclk     (aclk),
            .en       (pipe_en),
            .pix      (pix[k]),
            .scale    (scale_reg[k*COEF_W +: COEF_W]),
            .bias     (bias_reg[k*COEF_W +: COEF_W]),
            .active   (active[k]),
            .lane_out (lane_q[k])
        );
    end

    assign res.lane0 = lane_q[0];
    assign res.lane1 = lane_q[1];
    assign res.lane2 = lane_q[2];
    assign res.lane3 = lane_q[3];
    assign res.last  = last2_reg;

    pq8_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2_reg),
        .in_data   (res),
        .in_ready  (pipe_en),
        .out_valid (m_valid),
        .out_data  (out_res),
        .out_ready (m_ready)
    );

    assign m_lane0          = $signed(out_res.lane0);
    assign m_lane1          = $signed(out_res.lane1);
    assign m_lane2          = $signed(out_res.lane2);
    assign m_lane3          = $signed(out_res.lane3);
    assign m_last_pixel_out = out_res.last;

endmodule

`default_nettype wire

// ----- rtl/pq8_lane.sv -----
`default_nettype none

module pq8_lane (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [pq8_pkg::PIX_W-1:0]   pix,
    input  wire logic [pq8_pkg::COEF_W-1:0]  scale,
    input  wire logic [pq8_pkg::COEF_W-1:0]  bias,
    input  wire logic                        active,
    output logic      [pq8_pkg::PIX_W-1:0]   lane_out
);
    import pq8_pkg::*;

    localparam int unsigned Q_W = ACC_W - FRAC_BITS;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [COEF_W-1:0] bias_reg;
    logic                     active_reg;
    logic [PIX_W-1:0]         lane_reg;
    logic [PIX_W-1:0]         lane_next;

    // stage 1: one multiply, registered
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= PROD_W'($signed(scale) * $signed({1'b0, pix}));
            bias_reg   <= $signed(bias);
            active_reg <= active;
        end
    end

    // stage 2: add bias, round half away from zero, saturate
    always_comb begin
        logic signed [ACC_W-1:0] acc;
        logic [ACC_W-1:0]        mag;
        logic [Q_W-1:0]          q;
        logic                    neg;
        acc = ACC_W'(prod_reg) + ACC_W'(bias_reg <<< BIAS_SHIFT);
        neg = acc[ACC_W-1];
        mag = neg ? ACC_W'(-acc) : ACC_W'(acc);
        q   = Q_W'((mag + ACC_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        if (!active_reg) begin
            lane_next = '0;
        end else if (neg) begin
            lane_next = (q > Q_W'(128)) ? 8'h80 : PIX_W'(-q);
        end else begin
            lane_next = (q > Q_W'(127)) ? 8'h7f : PIX_W'(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

`default_nettype wire

// ----- rtl/pq8_merge.sv -----
`default_nettype none

module pq8_merge (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire pq8_pkg::pq8_result_t in_data,
    output logic                      in_ready,
    output logic                      out_valid,
    output pq8_pkg::pq8_result_t      out_data,
    input  wire logic                 out_ready
);
    import pq8_pkg::*;

    pq8_result_t out_reg;
    pq8_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        out_free;
    logic        in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            if (out_free) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            if (out_free) begin
                out_reg <= in_data;
            end else begin
                skid_reg <= in_data;
            end
        end else if (out_free && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ----- rtl/pq8_checker.sv -----
`default_nettype none

module pq8_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic signed [7:0]              m_lane0,
    input wire logic signed [7:0]              m_lane1,
    input wire logic signed [7:0]              m_lane2,
    input wire logic signed [7:0]              m_lane3,
    input wire logic                           m_last_pixel_out
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lane0) && $stable(m_lane1)
            && $stable(m_lane2) && $stable(m_lane3) && $stable(m_last_pixel_out))
        else $error("result beat changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a draining output always frees the skid slot, so s_ready is high the next cycle
    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |=> s_ready)
        else $error("input not ready after output drained");

endmodule

bind pixel_quantize_to_int8_unit pq8_checker u_pq8_checker (.*);

`default_nettype wire

// ----- tb/pixel_quantize_to_int8_unit_tb.sv -----
`timescale 1ns / 100ps

module pixel_quantize_to_int8_unit_tb;
    import pq8_pkg::*;

    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int PRESSURE_PHASE  = 4;
    localparam int RGB_LANES       = 3;
    localparam int GRAY_LANES      = 1;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [63:0] scale;
        logic [63:0] bias;
        pq8_fmt_t    fmt;
        logic        swap;
        logic        keep;
    } quant_cfg_t;

    typedef struct packed {
        quant_cfg_t  cfg;
        logic [31:0] pix;      // {chan3, chan2, chan1, chan0}
        logic        last;
        logic        typed;
        logic [31:0] want;     // {lane3, lane2, lane1, lane0}
    } pixel_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SCALE;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_chan0 = '0;
    logic [7:0]           s_chan1 = '0;
    logic [7:0]           s_chan2 = '0;
    logic [7:0]           s_chan3 = '0;
    logic                 s_last_pixel = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [7:0]    m_lane0;
    logic signed [7:0]    m_lane1;
    logic signed [7:0]    m_lane2;
    logic signed [7:0]    m_lane3;
    logic                 m_last_pixel_out;

    // travels with the beat: a hand-typed result to use instead of the predictor
    logic                 beat_typed = 1'b0;
    logic [31:0]          beat_want = '0;

    quant_cfg_t   cfg_shadow;
    pq8_result_t  lanes_pending[$];
    pixel_row_t   dir_rows[$];
    pq8_result_t  due;
    pq8_result_t  seen;
    int           bad_results = 0;
    int           quiet_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_req = 0;
    int           hold_left = 0;

    pixel_quantize_to_int8_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_chan0          (s_chan0),
        .s_chan1          (s_chan1),
        .s_chan2          (s_chan2),
        .s_chan3          (s_chan3),
        .s_last_pixel     (s_last_pixel),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_lane0          (m_lane0),
        .m_lane1          (m_lane1),
        .m_lane2          (m_lane2),
        .m_lane3          (m_lane3),
        .m_last_pixel_out (m_last_pixel_out)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic [7:0] quantize_lane(input int lane, input logic [7:0] px);
        int coef;
        int offs;
        int acc;
        int mag;
        int q;
        int r;
        coef = $signed(cfg_shadow.scale[16*lane +: 16]);
        offs = $signed(cfg_shadow.bias[16*lane +: 16]);
        // bias is Q.6, scale*byte is Q.10
        acc = coef * int'(px) + offs * 16;
        mag = (acc < 0) ? -acc : acc;
        q = (mag + 512) >> 10;
        if (acc < 0) begin
            r = (q > 128) ? -128 : -q;
        end else begin
            r = (q > 127) ? 127 : q;
        end
        return 8'(r);
    endfunction

    function automatic pq8_result_t quantize_pixel(input logic [31:0] pix, input logic last);
        pq8_result_t res;
        int active;
        case (cfg_shadow.fmt)
            FMT_BGRA: active = cfg_shadow.keep ? LANES : RGB_LANES;
            FMT_BGR:  active = RGB_LANES;
            default:  active = GRAY_LANES;
        endcase
        res = '0;
        res.last = last;
        if (active == GRAY_LANES) begin
            res.lane0 = quantize_lane(0, pix[7:0]);
        end else begin
            res.lane0 = quantize_lane(0, cfg_shadow.swap ? pix[23:16] : pix[7:0]);
            res.lane1 = quantize_lane(1, pix[15:8]);
            res.lane2 = quantize_lane(2, cfg_shadow.swap ? pix[7:0] : pix[23:16]);
            if (active == LANES) begin
                res.lane3 = quantize_lane(3, pix[31:24]);
            end
        end
        return res;
    endfunction

    function automatic quant_cfg_t mk_cfg(input logic [63:0] scale, input logic [63:0] bias,
                                          input pq8_fmt_t fmt, input logic swap,
                                          input logic keep);
        quant_cfg_t c;
        c.scale = scale;
        c.bias = bias;
        c.fmt = fmt;
        c.swap = swap;
        c.keep = keep;
        return c;
    endfunction

    function automatic quant_cfg_t random_cfg();
        quant_cfg_t c;
        for (int k = 0; k < LANES; k++) begin
            if ($urandom_range(0, 1)) begin
                // mostly unsaturated: |scale| <= 0.5, |bias| <= 64
                c.scale[16*k +: 16] = 16'($urandom_range(0, 1024)) - 16'd512;
                c.bias[16*k +: 16]  = 16'($urandom_range(0, 8192)) - 16'd4096;
            end else begin
                c.scale[16*k +: 16] = 16'($urandom);
                c.bias[16*k +: 16]  = 16'($urandom);
            end
        end
        c.fmt = pq8_fmt_t'($urandom_range(0, 3));
        c.swap = 1'($urandom_range(0, 1));
        c.keep = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic add_row(input quant_cfg_t c, input logic [31:0] pix, input logic last,
                           input logic typed, input logic [31:0] want);
        pixel_row_t row;
        row.cfg = c;
        row.pix = pix;
        row.last = last;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
    endtask

    // narrow registers get junk in their upper bits, and one unused index is hit
    task automatic load_cfg(input quant_cfg_t c);
        logic [CFG_W-1:0] junk;
        write_reg(REG_SCALE, c.scale);
        write_reg(REG_BIAS, c.bias);
        junk = {$urandom, $urandom};
        junk[1:0] = c.fmt;
        write_reg(REG_FMT, junk);
        junk = {$urandom, $urandom};
        junk[0] = c.swap;
        write_reg(REG_SWAP, junk);
        junk = {$urandom, $urandom};
        junk[0] = c.keep;
        write_reg(REG_KEEP, junk);
        write_reg(REG_KEEP + CFG_IDX_W'($urandom_range(1, 3)), {$urandom, $urandom});
        cfg_we <= 1'b0;
        cfg_shadow = c;
    endtask

    task automatic settle();
        while (lanes_pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // returns in the step of the accepting edge, s_valid still high
    task automatic send_pixel(input logic [31:0] pix, input logic last, input logic typed,
                              input logic [31:0] want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_chan3, s_chan2, s_chan1, s_chan0} <= pix;
        s_last_pixel <= last;
        beat_typed <= typed;
        beat_want <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // receiver: random stalls, plus a long hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // predictor push on input beats, compare on output beats
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (beat_typed) begin
                    lanes_pending.push_back({beat_want, s_last_pixel});
                end else begin
                    lanes_pending.push_back(quantize_pixel({s_chan3, s_chan2, s_chan1, s_chan0},
                                                           s_last_pixel));
                end
            end
            if (m_valid && m_ready) begin
                seen = {m_lane3, m_lane2, m_lane1, m_lane0, m_last_pixel_out};
                if (lanes_pending.size() == 0) begin
                    if (bad_results < MAX_REPORTS) begin
                        $display("%t unexpected result beat: lanes %0d %0d %0d %0d last %0b",
                                 $realtime, m_lane0, m_lane1, m_lane2, m_lane3,
                                 m_last_pixel_out);
                    end
                    bad_results++;
                end else begin
                    due = lanes_pending.pop_front();
                    if (seen !== due) begin
                        if (bad_results < MAX_REPORTS) begin
                            $write("%t mismatch: exp lanes %0d %0d %0d %0d last %0b",
                                   $realtime, $signed(due.lane0), $signed(due.lane1),
                                   $signed(due.lane2), $signed(due.lane3), due.last);
                            $display(", got %0d %0d %0d %0d last %0b",
                                     m_lane0, m_lane1, m_lane2, m_lane3, m_last_pixel_out);
                        end
                        bad_results++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[pixel_quantize_to_int8_unit] ERROR");
        $finish;
    end

    initial begin
        quant_cfg_t reset_cfg;
        quant_cfg_t sat_hi;
        quant_cfg_t sat_lo;
        quant_cfg_t unity;
        quant_cfg_t mixed;
        reset_cfg = mk_cfg('0, '0, FMT_BGRA, 1'b0, 1'b1);
        sat_hi = mk_cfg(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, FMT_BGRA, 1'b0, 1'b1);
        sat_lo = mk_cfg(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, FMT_BGRA, 1'b0, 1'b1);
        unity = mk_cfg(64'h0400_0400_0400_0400, '0, FMT_BGRA, 1'b0, 1'b1);
        mixed = mk_cfg(64'h0123_F456_00C8_FF38, 64'hFE40_0100_0C80_F380, FMT_BGRA, 1'b0, 1'b1);
        cfg_shadow = reset_cfg;

        // first rows run on the reset values of the registers
        add_row(reset_cfg, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000);
        add_row(reset_cfg, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000);
        add_row(sat_hi, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7F7F_7F7F);
        add_row(sat_hi, 32'h0000_0000, 1'b0, 1'b1, 32'h7F7F_7F7F);
        add_row(sat_lo, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h8080_8080);
        add_row(sat_lo, 32'h0000_0000, 1'b1, 1'b1, 32'h8080_8080);
        add_row(unity, 32'h0403_0201, 1'b0, 1'b1, 32'h0403_0201);
        add_row(unity, 32'h00C8_807F, 1'b1, 1'b1, 32'h007F_7F7F);
        // exact halves round away from zero
        add_row(mk_cfg(64'hFE00_0200_FE00_0200, '0, FMT_BGRA, 1'b0, 1'b1),
                32'h0303_0101, 1'b0, 1'b1, 32'hFE02_FF01);
        add_row(mk_cfg('0, 64'hFFE0_0020_FFE0_0020, FMT_BGRA, 1'b0, 1'b1),
                32'hA5A5_5A5A, 1'b1, 1'b1, 32'hFF01_FF01);
        add_row(mk_cfg('0, 64'h001F_FFE1_001F_FFE1, FMT_BGRA, 1'b0, 1'b1),
                32'h5A5A_A5A5, 1'b0, 1'b0, '0);
        add_row(mk_cfg(unity.scale, '0, FMT_BGRA, 1'b1, 1'b1),
                32'h281E_140A, 1'b0, 1'b1, 32'h280A_141E);
        add_row(mk_cfg(unity.scale, '0, FMT_BGR, 1'b0, 1'b1),
                32'h281E_140A, 1'b1, 1'b1, 32'h001E_140A);
        add_row(mk_cfg(unity.scale, '0, FMT_BGR, 1'b1, 1'b0),
                32'h281E_140A, 1'b0, 1'b1, 32'h000A_141E);
        add_row(mk_cfg(unity.scale, '0, FMT_GRAY, 1'b1, 1'b1),
                32'h281E_140A, 1'b1, 1'b1, 32'h0000_000A);
        add_row(mk_cfg(unity.scale, '0, FMT_RSVD, 1'b0, 1'b0),
                32'h281E_140A, 1'b0, 1'b1, 32'h0000_000A);
        add_row(mk_cfg(unity.scale, '0, FMT_BGRA, 1'b0, 1'b0),
                32'h281E_140A, 1'b1, 1'b1, 32'h001E_140A);
        add_row(mixed, 32'hFF80_017F, 1'b0, 1'b0, '0);
        add_row(mixed, 32'h00FF_AA55, 1'b1, 1'b0, '0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg != cfg_shadow) begin
                s_valid <= 1'b0;
                settle();
                load_cfg(dir_rows[i].cfg);
            end
            send_pixel(dir_rows[i].pix, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            s_valid <= 1'b0;
            settle();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            if (ph == 0) begin
                load_cfg(sat_hi);
            end else if (ph == 1) begin
                load_cfg(sat_lo);
            end else begin
                load_cfg(random_cfg());
            end
            // output blocked while the sender keeps pushing: pipe fills, s_ready drops
            if (ph == PRESSURE_PHASE) hold_req = HOLD_CYCLES;
            repeat (ITEMS_PER_PHASE) begin
                send_pixel($urandom, ($urandom_range(0, 7) == 0), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        settle();
        if (bad_results == 0) begin
            $display("[pixel_quantize_to_int8_unit] OK");
        end else begin
            $display("[pixel_quantize_to_int8_unit] ERROR");
        end
        $finish;
    end

endmodule
